// ===== sv/gtp_tunnel_id_learning_table_unit_assert.svh =====
// assertion macros for the tunnel-id learning table
`ifndef GTP_TUNNEL_ID_LEARNING_TABLE_UNIT_ASSERT_SVH
`define GTP_TUNNEL_ID_LEARNING_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define GTPLT_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gtplt assertion failed");

// next-cycle implication, disabled in reset
`define GTPLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gtplt assertion failed");

`endif

// ===== sv/gtplt_pkg.sv =====
// shared types and constants of the tunnel-id learning table
package gtplt_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned TEID_W = 32;

  localparam logic [7:0]        UDP_PROTOCOL    = 8'd17;
  localparam logic [ADDR_W-1:0] CORE_ADDR_RESET = 32'hC0A8_3D05;
  localparam logic [ADDR_W-1:0] BS_ADDR_RESET   = 32'hC0A8_0169;

  localparam logic [0:0] REG_CORE_ADDR = 1'd0;
  localparam logic [0:0] REG_BS_ADDR   = 1'd1;

  localparam logic [1:0] STATUS_IGNORED = 2'd0;
  localparam logic [1:0] STATUS_UPDATED = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;

  // search token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic              free;
    logic [TEID_W-1:0] old_up;
    logic [TEID_W-1:0] old_dn;
  } token_t;

  // update broadcast to all cells
  typedef struct packed {
    logic              en;
    logic              claim;
    logic              set_up;
    logic              set_dn;
    logic [ADDR_W-1:0] addr;
    logic [TEID_W-1:0] up;
    logic [TEID_W-1:0] dn;
  } write_t;

endpackage

// ===== sv/gtplt_cell.sv =====
// one table slot with its stage of the search chain
module gtplt_cell #(
  parameter int IDX_W = 5,
  parameter int INDEX = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [gtplt_pkg::ADDR_W-1:0]  key,
  input  gtplt_pkg::token_t             tin,
  input  logic [IDX_W-1:0]              tin_idx,
  output gtplt_pkg::token_t             tout,
  output logic [IDX_W-1:0]              tout_idx,
  input  gtplt_pkg::write_t             wr,
  input  logic [IDX_W-1:0]              wr_idx
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic                         used;
  logic [gtplt_pkg::ADDR_W-1:0] addr;
  logic [gtplt_pkg::TEID_W-1:0] up;
  logic [gtplt_pkg::TEID_W-1:0] dn;

  gtplt_pkg::token_t tout_next;
  logic [IDX_W-1:0]  tout_idx_next;
  logic              match;
  logic              is_free;
  logic              sel;

  assign match   = used && (addr == key);
  assign is_free = (up == '0);
  assign sel     = wr.en && (wr_idx == MY_IDX);

  always_comb begin
    tout_next     = tin;
    tout_idx_next = tin_idx;
    if (!tin.hit && match) begin
      tout_next.hit    = 1'b1;
      tout_next.old_up = up;
      tout_next.old_dn = dn;
      tout_idx_next    = MY_IDX;
    end else if (!tin.hit && !tin.free && is_free) begin
      tout_next.free   = 1'b1;
      tout_next.old_up = up;
      tout_next.old_dn = dn;
      tout_idx_next    = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= 1'b0;
      up         <= '0;
      dn         <= '0;
      tout.valid <= 1'b0;
    end else begin
      tout     <= tout_next;
      tout_idx <= tout_idx_next;
      if (sel) begin
        if (wr.claim) begin
          used <= 1'b1;
          addr <= wr.addr;
        end
        if (wr.set_up) begin
          up <= wr.up;
        end
        if (wr.set_dn) begin
          dn <= wr.dn;
        end
      end
    end
  end

endmodule

// ===== sv/gtp_tunnel_id_learning_table_unit.sv =====
// top level of the tunnel-id learning table
// Learns uplink and downlink TEIDs per UE address in a table of TABLE_DEPTH slots,
// built as a row of cells, one slot per cell. A search token walks the row one
// cell per clock, picking up the lowest slot holding the key or else the lowest
// slot with a zero uplink TEID; the chosen slot is then written as the result enters the output register.
// An item that updates the table or finds it full holds off the next acceptance
// until its token has walked through all the cells; an ignored item (not UDP or
// addressed to neither register) skips the walk and goes straight to finishing.
// A new transaction is taken while the previous result still waits in the
// output register. The two address registers should be written only while idle.
`include "gtp_tunnel_id_learning_table_unit_assert.svh"

module gtp_tunnel_id_learning_table_unit #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  outer_protocol,
  input  logic [31:0] outer_dst,
  input  logic [31:0] tunnel_id,
  input  logic [31:0] inner_src,
  input  logic [31:0] inner_dst,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [4:0]  slot,
  output logic [31:0] ue_addr,
  output logic [31:0] uplink_id,
  output logic [31:0] downlink_id,
  output logic        complete
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;
  typedef enum logic [1:0] {DIR_NONE, DIR_UP, DIR_DOWN} dir_t;

  state_t state;
  dir_t   dir;
  dir_t   in_dir;

  logic [31:0] core_addr;
  logic [31:0] base_station_addr;
  logic [31:0] key;
  logic [31:0] teid;
  logic        scan_start;

  gtplt_pkg::token_t res_tok;
  logic [IDX_W-1:0]  res_idx;

  gtplt_pkg::token_t tok [0:TABLE_DEPTH];
  logic [IDX_W-1:0]  tidx [0:TABLE_DEPTH];
  gtplt_pkg::write_t wr;

  logic        in_acc;
  logic        out_free;
  logic        res_found;
  logic [1:0]  status_next;
  logic [31:0] up_new;
  logic [31:0] dn_new;
  logic        out_zero;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    in_dir = DIR_NONE;
    if (outer_protocol == gtplt_pkg::UDP_PROTOCOL) begin
      if (outer_dst == core_addr) begin
        in_dir = DIR_UP;
      end else if (outer_dst == base_station_addr) begin
        in_dir = DIR_DOWN;
      end
    end
  end

  // token entering the first cell
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = scan_start;
    tidx[0]      = '0;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    gtplt_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .key      (key),
      .tin      (tok[i]),
      .tin_idx  (tidx[i]),
      .tout     (tok[i+1]),
      .tout_idx (tidx[i+1]),
      .wr       (wr),
      .wr_idx   (res_idx)
    );
  end

  assign res_found = res_tok.hit || res_tok.free;

  always_comb begin
    if (dir == DIR_NONE) begin
      status_next = gtplt_pkg::STATUS_IGNORED;
    end else if (!res_found) begin
      status_next = gtplt_pkg::STATUS_FULL;
    end else begin
      status_next = gtplt_pkg::STATUS_UPDATED;
    end
    up_new = res_tok.old_up;
    dn_new = res_tok.old_dn;
    if (dir == DIR_UP) begin
      up_new = (teid == '0) ? 32'd1 : teid;
    end
    if (dir == DIR_DOWN) begin
      dn_new = teid;
    end
  end

  always_comb begin
    wr        = '0;
    wr.en     = (state == S_FINISH) && out_free && (status_next == gtplt_pkg::STATUS_UPDATED);
    wr.claim  = !res_tok.hit;
    wr.set_up = (dir == DIR_UP);
    wr.set_dn = (dir == DIR_DOWN);
    wr.addr   = key;
    wr.up     = up_new;
    wr.dn     = dn_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      out_valid         <= 1'b0;
      scan_start        <= 1'b0;
      core_addr         <= gtplt_pkg::CORE_ADDR_RESET;
      base_station_addr <= gtplt_pkg::BS_ADDR_RESET;
    end else begin
      scan_start <= in_acc && (in_dir != DIR_NONE);
      if (cfg_write) begin
        case (cfg_index)
          gtplt_pkg::REG_CORE_ADDR: core_addr         <= cfg_data;
          gtplt_pkg::REG_BS_ADDR:   base_station_addr <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            key  <= (in_dir == DIR_UP) ? inner_src : inner_dst;
            teid <= tunnel_id;
            dir  <= in_dir;
            if (in_dir == DIR_NONE) begin
              state <= S_FINISH;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (tok[TABLE_DEPTH].valid) begin
            res_tok <= tok[TABLE_DEPTH];
            res_idx <= tidx[TABLE_DEPTH];
            state   <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= status_next;
            if (status_next == gtplt_pkg::STATUS_UPDATED) begin
              slot        <= 5'(res_idx);
              ue_addr     <= key;
              uplink_id   <= up_new;
              downlink_id <= dn_new;
              complete    <= (up_new != '0) && (dn_new != '0);
            end else begin
              slot        <= '0;
              ue_addr     <= '0;
              uplink_id   <= '0;
              downlink_id <= '0;
              complete    <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_zero = (uplink_id == '0) && (downlink_id == '0) && (ue_addr == '0) &&
                    (slot == '0) && !complete;

  `GTPLT_ASSERT_NOW(a_tail_only_in_scan, clk, rst, tok[TABLE_DEPTH].valid, state == S_SCAN)
  `GTPLT_ASSERT_NOW(a_rise_after_finish, clk, rst, $rose(out_valid), $past(state == S_FINISH))
  `GTPLT_ASSERT_NOW(a_no_update_zero, clk, rst, out_valid && (status != gtplt_pkg::STATUS_UPDATED), out_zero)
  `GTPLT_ASSERT_NEXT(a_write_delivers, clk, rst, wr.en, out_valid && (status == gtplt_pkg::STATUS_UPDATED))

endmodule
